// ===== sv/tdtd_pkg.sv =====
package tdtd_pkg;

    // Field widths of the stream items and configuration registers.
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 4;
    localparam int POS_W     = 12;
    localparam int TS_W      = 32;
    localparam int COUNT_W   = 2;
    localparam int PRESS_W   = 16;
    localparam int MOVE_W    = 12;
    localparam int WIN_W     = 16;
    localparam int MOVE_SQ_W = 2 * MOVE_W;

    // Number of slots that the slot field can address.
    localparam int SLOT_RANGE = 2 ** SLOT_W;

    // Input tdata layout, lowest bit first: slot, pos_x, pos_y, timestamp.
    localparam int S_SLOT_LSB = 0;
    localparam int S_X_LSB    = S_SLOT_LSB + SLOT_W;
    localparam int S_Y_LSB    = S_X_LSB + POS_W;
    localparam int S_TS_LSB   = S_Y_LSB + POS_W;
    localparam int S_USED_W   = S_TS_LSB + TS_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first: tap_x, tap_y.
    localparam int M_USED_W   = 2 * POS_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_PRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MOVE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DBL_WINDOW = 2'd2;

    localparam logic [PRESS_W-1:0]   MAX_PRESS_RST   = 16'd200;
    localparam logic [MOVE_W-1:0]    MAX_MOVE_RST    = 12'd20;
    localparam logic [MOVE_SQ_W-1:0] MOVE_SQ_RST     = 24'd400;
    localparam logic [WIN_W-1:0]     DBL_WINDOW_RST  = 16'd300;

    // Commands carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_DOWN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

    // Tap kinds carried in the output tuser.
    localparam logic [COUNT_W-1:0] COUNT_NONE   = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_SINGLE = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_DOUBLE = 2'd2;

    // Default parameter values.
    localparam int NUM_SLOTS_DEF  = 16;
    localparam int COORD_BITS_DEF = 12;

    typedef struct packed {
        logic set;
        logic clr;
    } store_ctrl_t;

    typedef struct packed {
        logic                emit;
        logic [COUNT_W-1:0]  count;
        logic                from_pending;
        logic                pend_set;
        logic                pend_clr;
        store_ctrl_t         store;
    } eval_t;

endpackage

// ===== sv/tdtd_slot_store.sv =====
module tdtd_slot_store
    import tdtd_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int CW        = COORD_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  store_ctrl_t       ctrl,
    input  logic [SLOT_W-1:0] slot,
    input  logic [TS_W-1:0]   wr_time,
    input  logic [CW-1:0]     wr_x,
    input  logic [CW-1:0]     wr_y,
    output logic              rd_active,
    output logic [TS_W-1:0]   rd_time,
    output logic [CW-1:0]     rd_x,
    output logic [CW-1:0]     rd_y
);

    // Slots beyond what the slot field reaches can never be addressed.
    localparam int DEPTH = (NUM_SLOTS < SLOT_RANGE) ? NUM_SLOTS : SLOT_RANGE;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0]  active_reg;
    logic [TS_W-1:0]   time_reg [DEPTH];
    logic [CW-1:0]     x_reg    [DEPTH];
    logic [CW-1:0]     y_reg    [DEPTH];

    logic              in_range;
    logic [IW-1:0]     idx;

    assign in_range = ((SLOT_W + 1)'(slot) < (SLOT_W + 1)'(DEPTH));
    assign idx      = slot[IW-1:0];

    // An entry out of range reads as inactive, so its data is never used.
    assign rd_active = in_range && active_reg[idx];
    assign rd_time   = time_reg[idx];
    assign rd_x      = x_reg[idx];
    assign rd_y      = y_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (in_range && ctrl.set)
        begin
            active_reg[idx] <= 1'b1;
        end
        else if (in_range && ctrl.clr)
        begin
            active_reg[idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_range && ctrl.set)
        begin
            time_reg[idx] <= wr_time;
            x_reg[idx]    <= wr_x;
            y_reg[idx]    <= wr_y;
        end
    end

endmodule

// ===== sv/tdtd_tap_eval.sv =====
module tdtd_tap_eval
    import tdtd_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF
)
(
    input  logic [CMD_W-1:0]     cmd,
    input  logic [TS_W-1:0]      ev_time,
    input  logic [CW-1:0]        ev_x,
    input  logic [CW-1:0]        ev_y,
    input  logic                 ent_active,
    input  logic [TS_W-1:0]      ent_time,
    input  logic [CW-1:0]        ent_x,
    input  logic [CW-1:0]        ent_y,
    input  logic                 pend_active,
    input  logic [TS_W-1:0]      pend_time,
    input  logic [PRESS_W-1:0]   max_press,
    input  logic [MOVE_SQ_W-1:0] move_sq,
    input  logic [WIN_W-1:0]     dbl_window,
    output eval_t                ev
);

    localparam int DW = (2 * CW + 1 > MOVE_SQ_W) ? 2 * CW + 1 : MOVE_SQ_W;

    logic [TS_W-1:0]   dur;
    logic [TS_W-1:0]   since_tap;
    logic [CW-1:0]     dx;
    logic [CW-1:0]     dy;
    logic [2*CW-1:0]   dx_sq;
    logic [2*CW-1:0]   dy_sq;
    logic [DW-1:0]     dist_sq;
    logic              is_tap;
    logic              window_over;

    // Time differences wrap modulo 2^32.
    assign dur       = ev_time - ent_time;
    assign since_tap = ev_time - pend_time;

    assign dx      = (ent_x > ev_x) ? (ent_x - ev_x) : (ev_x - ent_x);
    assign dy      = (ent_y > ev_y) ? (ent_y - ev_y) : (ev_y - ent_y);
    assign dx_sq   = (2 * CW)'(dx) * (2 * CW)'(dx);
    assign dy_sq   = (2 * CW)'(dy) * (2 * CW)'(dy);
    assign dist_sq = DW'(dx_sq) + DW'(dy_sq);

    assign is_tap      = (dur <= TS_W'(max_press)) && (dist_sq < DW'(move_sq));
    assign window_over = (since_tap >= TS_W'(dbl_window));

    always_comb
    begin
        ev = '0;
        ev.count = COUNT_NONE;
        unique case (cmd)
            CMD_FLUSH:
            begin
                if (pend_active && window_over)
                begin
                    ev.emit         = 1'b1;
                    ev.count        = COUNT_SINGLE;
                    ev.from_pending = 1'b1;
                    ev.pend_clr     = 1'b1;
                end
            end
            CMD_DOWN:
            begin
                ev.store.set = 1'b1;
            end
            CMD_UP:
            begin
                if (ent_active)
                begin
                    ev.store.clr = 1'b1;
                    if (is_tap && pend_active)
                    begin
                        ev.emit     = 1'b1;
                        ev.count    = COUNT_DOUBLE;
                        ev.pend_clr = 1'b1;
                    end
                    else if (is_tap)
                    begin
                        ev.pend_set = 1'b1;
                    end
                end
            end
            default:
            begin
                ev = '0;
            end
        endcase
    end

endmodule

// ===== sv/tap_double_tap_detector_core.sv =====
// Tap and double-tap detector. Each input item is a touch event (finger down,
// finger up, or a flush tick carrying the current time) and at most one tap
// report comes out per item. The block takes one item per clock cycle while
// no untaken report holds the output. An accepted item sits in the input
// register and, once the output is free, moves into the result register,
// which offers its report. All per-item work (slot lookup, the wrapped
// duration check and the squared distance compare) sits between those two
// registers. A report that is not taken holds the item behind it in the
// input register, and the input stalls until it is taken.
// The per-slot valid marks are cleared by reset at once, so the block is ready
// right after reset.
// A single tap is only reported on a flush tick that arrives once the double
// window has run out since the first tap's release; a second tap before that
// flush gives a double tap at the second press's down position. Configuration
// writes take effect on the next cycle and should be made only while no item
// is in flight.
module tap_double_tap_detector_core
    import tdtd_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // slot[3:0], pos_x[15:4], pos_y[27:16], timestamp[59:28], zero fill above
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tap_x[11:0], tap_y[23:12]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // tap_count[1:0]
    output logic [COUNT_W-1:0]    m_axis_tuser
);

    // Coordinates are kept in the low COORD_BITS bits of the position fields.
    localparam int CW = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;

    // Configuration registers. The squared move limit is formed at write time
    // so the per-item path holds only the two coordinate squares.
    logic [PRESS_W-1:0]   max_press_reg;
    logic [MOVE_SQ_W-1:0] move_sq_reg;
    logic [WIN_W-1:0]     dbl_window_reg;
    logic [MOVE_W-1:0]    move_wdata;

    assign move_wdata = cfg_wdata[MOVE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_press_reg  <= MAX_PRESS_RST;
            move_sq_reg    <= MOVE_SQ_RST;
            dbl_window_reg <= DBL_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_PRESS:  max_press_reg  <= cfg_wdata[PRESS_W-1:0];
                REG_MAX_MOVE:   move_sq_reg    <= MOVE_SQ_W'(move_wdata) *
                                                  MOVE_SQ_W'(move_wdata);
                REG_DBL_WINDOW: dbl_window_reg <= cfg_wdata[WIN_W-1:0];
                default:        max_press_reg  <= max_press_reg;
            endcase
        end
    end

    // Input register. It refills in the same cycle that its item moves on, so
    // the stream runs at one item per cycle while the output is taken.
    logic              in_valid_reg;
    logic [CMD_W-1:0]  in_cmd_reg;
    logic [SLOT_W-1:0] in_slot_reg;
    logic [CW-1:0]     in_x_reg;
    logic [CW-1:0]     in_y_reg;
    logic [TS_W-1:0]   in_time_reg;

    logic              out_valid_reg;
    logic              out_free;
    logic              fire;
    logic              in_take;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_slot_reg <= s_axis_tdata[S_SLOT_LSB +: SLOT_W];
            in_x_reg    <= s_axis_tdata[S_X_LSB +: CW];
            in_y_reg    <= s_axis_tdata[S_Y_LSB +: CW];
            in_time_reg <= s_axis_tdata[S_TS_LSB +: TS_W];
        end
    end

    // Per-slot press records.
    store_ctrl_t     store_ctrl;
    logic            ent_active;
    logic [TS_W-1:0] ent_time;
    logic [CW-1:0]   ent_x;
    logic [CW-1:0]   ent_y;
    eval_t           ev;

    // The store only changes when the item in the input register moves on.
    assign store_ctrl.set = fire && ev.store.set;
    assign store_ctrl.clr = fire && ev.store.clr;

    tdtd_slot_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .CW        (CW)
    ) u_slot_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (store_ctrl),
        .slot      (in_slot_reg),
        .wr_time   (in_time_reg),
        .wr_x      (in_x_reg),
        .wr_y      (in_y_reg),
        .rd_active (ent_active),
        .rd_time   (ent_time),
        .rd_x      (ent_x),
        .rd_y      (ent_y)
    );

    // The first tap waiting for a second one or for its window to run out.
    logic            pend_reg;
    logic [CW-1:0]   pend_x_reg;
    logic [CW-1:0]   pend_y_reg;
    logic [TS_W-1:0] pend_time_reg;

    tdtd_tap_eval #(
        .CW          (CW)
    ) u_tap_eval (
        .cmd         (in_cmd_reg),
        .ev_time     (in_time_reg),
        .ev_x        (in_x_reg),
        .ev_y        (in_y_reg),
        .ent_active  (ent_active),
        .ent_time    (ent_time),
        .ent_x       (ent_x),
        .ent_y       (ent_y),
        .pend_active (pend_reg),
        .pend_time   (pend_time_reg),
        .max_press   (max_press_reg),
        .move_sq     (move_sq_reg),
        .dbl_window  (dbl_window_reg),
        .ev          (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (fire && ev.pend_set)
        begin
            pend_reg <= 1'b1;
        end
        else if (fire && ev.pend_clr)
        begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && ev.pend_set)
        begin
            pend_x_reg    <= ent_x;
            pend_y_reg    <= ent_y;
            pend_time_reg <= in_time_reg;
        end
    end

    // Result register. A single tap reports the pending position, a double
    // tap the down position of the second press.
    logic [CW-1:0]      out_x_reg;
    logic [CW-1:0]      out_y_reg;
    logic [COUNT_W-1:0] out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= ev.emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && ev.emit)
        begin
            out_x_reg     <= ev.from_pending ? pend_x_reg : ent_x;
            out_y_reg     <= ev.from_pending ? pend_y_reg : ent_y;
            out_count_reg <= ev.count;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({POS_W'(out_y_reg), POS_W'(out_x_reg)});
    assign m_axis_tuser  = out_count_reg;

endmodule

// ===== sv/tdtd_checker.sv =====
module tdtd_checker
    import tdtd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [CMD_W-1:0]      s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [COUNT_W-1:0]    m_axis_tuser
);

    // A report that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Every report is a single or a double tap.
    a_count_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == COUNT_SINGLE || m_axis_tuser == COUNT_DOUBLE))
        else $error("bad tap count");

    // A single tap on an empty output comes from a flush accepted into the input register and moved on.
    a_single_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) && m_axis_tuser == COUNT_SINGLE |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_FLUSH, 2))
        else $error("single tap without a flush item");

    // A double tap on an empty output comes from a finger up accepted into the input register and moved on.
    a_double_from_up: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) && m_axis_tuser == COUNT_DOUBLE |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_UP, 2))
        else $error("double tap without a finger up item");

endmodule

bind tap_double_tap_detector_core tdtd_checker u_tdtd_checker (.*);

// ===== test/tap_double_tap_detector_core_tb.sv =====
`timescale 1ns / 1ps

module tap_double_tap_detector_core_tb;
    import tdtd_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    // A correct run ends well before this limit even when every item waits out
    // the longest sender gap and every tap report the longest receiver stall.
    localparam int CYCLE_LIMIT   = 800000;
    // Two pipeline registers; items that report nothing are gone after this.
    localparam int SETTLE_CYCLES = 8;
    localparam int END_WAIT_MAX  = 5000;
    localparam int REPORT_MAX    = 10;
    localparam int LONG_HOLD_OFF = 400;

    // The command field has one code that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One tap report as it leaves the block.
    typedef struct packed {
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [COUNT_W-1:0] count;
    } tap_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [COUNT_W-1:0]    m_axis_tuser;

    tap_double_tap_detector_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Gesture tracker: the testbench's own view of the registers, the per-slot
    // press records and the single tap waiting for its partner.
    logic [PRESS_W-1:0] press_limit;
    logic [MOVE_W-1:0]  move_limit;
    logic [WIN_W-1:0]   window_len;
    bit                 finger_down [SLOT_RANGE];
    logic [TS_W-1:0]    down_time   [SLOT_RANGE];
    logic [POS_W-1:0]   down_x      [SLOT_RANGE];
    logic [POS_W-1:0]   down_y      [SLOT_RANGE];
    bit                 tap_held;
    logic [POS_W-1:0]   held_x;
    logic [POS_W-1:0]   held_y;
    logic [TS_W-1:0]    held_release;

    // Tap reports predicted at input acceptance, oldest first.
    tap_report_t taps_due[$];

    int              mismatch_count = 0;
    int              cycle_count = 0;
    int              hold_off_req = 0;
    int              items_sent = 0;
    bit              tx_idle_en = 1'b0;
    bit              rx_idle_en = 1'b0;
    // Running millisecond clock that the gesture generator follows; it wraps.
    logic [TS_W-1:0] now_ms;

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
        begin
            $display("%s", msg);
        end
    endtask

    task automatic reset_tracker();
        press_limit  = MAX_PRESS_RST;
        move_limit   = MAX_MOVE_RST;
        window_len   = DBL_WINDOW_RST;
        tap_held     = 1'b0;
        held_x       = '0;
        held_y       = '0;
        held_release = '0;
        for (int i = 0; i < SLOT_RANGE; i++)
        begin
            finger_down[i] = 1'b0;
            down_time[i]   = '0;
            down_x[i]      = '0;
            down_y[i]      = '0;
        end
    endtask

    // Works out what one touch event does to the tracker and whether it
    // reports a tap. Durations are differences on a wrapping 32-bit clock and
    // the travel test compares squared distances, so no root is needed.
    function automatic bit predict_tap(input logic [CMD_W-1:0] cmd,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [POS_W-1:0] x,
                                       input logic [POS_W-1:0] y,
                                       input logic [TS_W-1:0] t,
                                       output tap_report_t rep);
        logic [TS_W-1:0]  elapsed;
        longint unsigned  dx;
        longint unsigned  dy;
        longint unsigned  lim;
        rep = '0;
        if (cmd == CMD_FLUSH)
        begin
            elapsed = t - held_release;
            if (tap_held && elapsed >= window_len)
            begin
                rep.x     = held_x;
                rep.y     = held_y;
                rep.count = COUNT_SINGLE;
                tap_held  = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (cmd != CMD_DOWN && cmd != CMD_UP)
        begin
            return 1'b0;
        end
        if (int'(slot) >= NUM_SLOTS_DEF)
        begin
            return 1'b0;
        end
        if (cmd == CMD_DOWN)
        begin
            finger_down[slot] = 1'b1;
            down_time[slot]   = t;
            down_x[slot]      = x;
            down_y[slot]      = y;
            return 1'b0;
        end
        if (!finger_down[slot])
        begin
            return 1'b0;
        end
        finger_down[slot] = 1'b0;
        elapsed = t - down_time[slot];
        dx  = down_x[slot];
        dx  = (dx > x) ? dx - x : x - dx;
        dy  = down_y[slot];
        dy  = (dy > y) ? dy - y : y - dy;
        lim = move_limit;
        if (elapsed > press_limit || dx * dx + dy * dy >= lim * lim)
        begin
            return 1'b0;
        end
        if (tap_held)
        begin
            tap_held  = 1'b0;
            rep.x     = down_x[slot];
            rep.y     = down_y[slot];
            rep.count = COUNT_DOUBLE;
            return 1'b1;
        end
        tap_held     = 1'b1;
        held_x       = down_x[slot];
        held_y       = down_y[slot];
        held_release = t;
        return 1'b0;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Receiver side. A hold-off request from the stimulus takes precedence over
    // the random stalls; the stall length is counted here cycle by cycle.
    initial
    begin : tap_sink
        int hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0)
            begin
                if (hold_off_req != 0)
                begin
                    hold_left    = hold_off_req;
                    hold_off_req = 0;
                end
                else if (rx_idle_en && $urandom_range(0, 99) < 25)
                begin
                    hold_left = pick_gap();
                end
            end
            if (hold_left != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Every accepted tap report is checked against the oldest prediction.
    always @(posedge clk)
    begin : tap_check
        tap_report_t        want;
        logic [POS_W-1:0]   got_x;
        logic [POS_W-1:0]   got_y;
        logic [COUNT_W-1:0] got_count;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_x     = m_axis_tdata[0 +: POS_W];
            got_y     = m_axis_tdata[POS_W +: POS_W];
            got_count = m_axis_tuser;
            if (taps_due.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected tap report x=%0d y=%0d count=%0d",
                                        got_x, got_y, got_count));
            end
            else
            begin
                want = taps_due.pop_front();
                if (got_x !== want.x || got_y !== want.y || got_count !== want.count)
                begin
                    flag_mismatch($sformatf(
                        "tap report mismatch: expected x=%0d y=%0d count=%0d, got x=%0d y=%0d count=%0d",
                        want.x, want.y, want.count, got_x, got_y, got_count));
                end
            end
        end
    end

    // Offers one touch event after a random gap, waits for it to be taken and
    // records the tap report it should cause.
    task automatic send_touch(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                              input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [TS_W-1:0] t);
        logic [S_TDATA_W-1:0] word;
        tap_report_t          rep;
        int                   gap;
        word = '0;
        word[S_SLOT_LSB +: SLOT_W] = slot;
        word[S_X_LSB +: POS_W]     = x;
        word[S_Y_LSB +: POS_W]     = y;
        word[S_TS_LSB +: TS_W]     = t;
        gap = tx_idle_en ? pick_gap() : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (!s_axis_tready);
        if (predict_tap(cmd, slot, x, y, t, rep))
        begin
            taps_due.push_back(rep);
        end
        if (cmd != CMD_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // Stops offering items and lets every predicted report and every item
    // still in the pipeline drain out.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (taps_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_MAX_PRESS:  press_limit = value[PRESS_W-1:0];
            REG_MAX_MOVE:   move_limit  = value[MOVE_W-1:0];
            REG_DBL_WINDOW: window_len  = value[WIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input int press, input int move, input int window);
        wait_idle();
        write_reg(REG_MAX_PRESS, CFG_DATA_W'(press));
        write_reg(REG_MAX_MOVE, CFG_DATA_W'(move));
        write_reg(REG_DBL_WINDOW, CFG_DATA_W'(window));
    endtask

    // Press duration: mostly within the limit, some right at its edge, a few
    // anywhere on the wrapping clock.
    function automatic logic [TS_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return TS_W'($urandom_range(0, int'(press_limit)));
        end
        if (r < 85)
        begin
            return TS_W'(press_limit) + TS_W'($urandom_range(0, 2));
        end
        return $urandom;
    endfunction

    // Release coordinate a random distance away from the press, on the scale of
    // the travel limit so both sides of the test are hit.
    function automatic logic [POS_W-1:0] nudge(input logic [POS_W-1:0] p);
        int d;
        int v;
        d = $urandom_range(0, int'(move_limit));
        if ($urandom_range(0, 9) == 0)
        begin
            d = $urandom_range(0, 4095);
        end
        v = $urandom_range(0, 1) ? int'(p) + d : int'(p) - d;
        if (v < 0)
        begin
            v = int'(p) + d;
        end
        if (v > 4095)
        begin
            v = int'(p) - d;
        end
        if (v < 0)
        begin
            v = 0;
        end
        return POS_W'(v);
    endfunction

    // One gesture: usually a press and release, sometimes two fingers at once,
    // often followed by a flush near the end of the double-tap window. A share
    // of the items are stray flushes or fully random noise.
    task automatic random_gesture();
        logic [SLOT_W-1:0] slot_a;
        logic [SLOT_W-1:0] slot_b;
        logic [POS_W-1:0]  xa;
        logic [POS_W-1:0]  ya;
        logic [POS_W-1:0]  xb;
        logic [POS_W-1:0]  yb;
        logic [TS_W-1:0]   t_up;
        bit                two_finger;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            send_touch(CMD_W'($urandom_range(0, 3)), SLOT_W'($urandom), POS_W'($urandom),
                       POS_W'($urandom), $urandom);
            return;
        end
        if (r < 20)
        begin
            now_ms = now_ms + TS_W'($urandom_range(0, 2 * int'(window_len) + 4));
            send_touch(CMD_FLUSH, SLOT_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                       now_ms);
            return;
        end
        if (r < 24)
        begin
            now_ms = $urandom;
        end
        slot_a     = SLOT_W'($urandom);
        slot_b     = SLOT_W'($urandom);
        xa         = POS_W'($urandom);
        ya         = POS_W'($urandom);
        xb         = POS_W'($urandom);
        yb         = POS_W'($urandom);
        two_finger = ($urandom_range(0, 4) == 0);
        now_ms     = now_ms + TS_W'($urandom_range(0, 20));
        send_touch(CMD_DOWN, slot_a, xa, ya, now_ms);
        if (two_finger)
        begin
            send_touch(CMD_DOWN, slot_b, xb, yb, now_ms + TS_W'($urandom_range(0, 5)));
        end
        t_up = now_ms + pick_duration();
        send_touch(CMD_UP, slot_a, nudge(xa), nudge(ya), t_up);
        if (two_finger)
        begin
            send_touch(CMD_UP, slot_b, nudge(xb), nudge(yb), t_up + TS_W'($urandom_range(0, 5)));
        end
        now_ms = t_up;
        if ($urandom_range(0, 2) == 0)
        begin
            // Land one millisecond before, on, or after the end of the window.
            now_ms = now_ms + TS_W'(window_len) + TS_W'($urandom_range(0, 2)) - 1;
            send_touch(CMD_FLUSH, SLOT_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                       now_ms);
        end
    endtask

    task automatic run_gestures(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
        begin
            random_gesture();
        end
    endtask

    // Hand-picked events under the reset limits (200 ms press, travel 20,
    // 300 ms window), each aimed at one boundary or corner of the behavior.
    task automatic test_directed_cases();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        // Flush with nothing pending, then the unused command with all ones.
        send_touch(CMD_FLUSH, 4'd0, 12'd0, 12'd0, 32'd0);
        send_touch(CMD_UNUSED, 4'hF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
        // Release on a slot that was never pressed.
        send_touch(CMD_UP, 4'd5, 12'd0, 12'd0, 32'd50);
        // Press lasting exactly the limit with travel 5: a tap, held pending.
        send_touch(CMD_DOWN, 4'd0, 12'd0, 12'd0, 32'd100);
        send_touch(CMD_UP, 4'd0, 12'd3, 12'd4, 32'd300);
        // One millisecond short of the window, then exactly on it.
        send_touch(CMD_FLUSH, 4'd0, 12'd0, 12'd0, 32'd599);
        send_touch(CMD_FLUSH, 4'd0, 12'd0, 12'd0, 32'd600);
        // Press across the wrap of the millisecond clock at the far corner.
        send_touch(CMD_DOWN, 4'd15, 12'hFFF, 12'hFFF, 32'hFFFF_FFF0);
        send_touch(CMD_UP, 4'd15, 12'hFFF, 12'd4076, 32'h0000_0010);
        // Second down on a busy slot replaces the first; the double tap is
        // reported at the replacement position.
        send_touch(CMD_DOWN, 4'd3, 12'd100, 12'd200, 32'd1000);
        send_touch(CMD_DOWN, 4'd3, 12'hFFF, 12'd0, 32'd1010);
        send_touch(CMD_UP, 4'd3, 12'hFFF, 12'd12, 32'd1020);
        // One millisecond too long.
        send_touch(CMD_DOWN, 4'd1, 12'd10, 12'd10, 32'd2000);
        send_touch(CMD_UP, 4'd1, 12'd10, 12'd10, 32'd2201);
        // Travel exactly at the limit is no tap; the slot is freed so a second
        // release is ignored. Just under the limit is a tap.
        send_touch(CMD_DOWN, 4'd2, 12'd500, 12'd500, 32'd3000);
        send_touch(CMD_UP, 4'd2, 12'd512, 12'd516, 32'd3001);
        send_touch(CMD_UP, 4'd2, 12'd512, 12'd516, 32'd3002);
        send_touch(CMD_DOWN, 4'd2, 12'd500, 12'd500, 32'd3100);
        send_touch(CMD_UP, 4'd2, 12'd512, 12'd515, 32'd3150);
        // A second tap long after the first still pairs with it.
        send_touch(CMD_DOWN, 4'd4, 12'd2048, 12'd1024, 32'h8000_0000);
        send_touch(CMD_UP, 4'd4, 12'd2048, 12'd1024, 32'h8000_0005);
        send_touch(CMD_FLUSH, 4'hF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
        // Zero-length press, then a flush whose window spans the clock wrap.
        send_touch(CMD_DOWN, 4'd6, 12'd7, 12'd9, 32'hFFFF_FF00);
        send_touch(CMD_UP, 4'd6, 12'd7, 12'd9, 32'hFFFF_FF00);
        send_touch(CMD_FLUSH, 4'd6, 12'd0, 12'd0, 32'h0000_002C);
        wait_idle();
    endtask

    // The receiver stops for a long stretch while quick taps keep coming, so
    // double-tap reports back up and the block has to stall its input.
    task automatic test_result_backpressure();
        wait_idle();
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        hold_off_req = LONG_HOLD_OFF;
        for (int i = 0; i < 40; i++)
        begin
            now_ms = now_ms + 32'd10;
            send_touch(CMD_DOWN, SLOT_W'(i), POS_W'(i * 97), POS_W'(i * 31), now_ms);
            send_touch(CMD_UP, SLOT_W'(i), POS_W'(i * 97), POS_W'(i * 31), now_ms + 32'd5);
        end
        wait_idle();
    endtask

    // Both ends of every register range, plus a few narrow settings.
    task automatic test_limit_extremes();
        set_limits(0, 0, 0);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b0;
        run_gestures(130);
        set_limits(65535, 4095, 65535);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        run_gestures(130);
        set_limits(1, 1, 1);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_gestures(130);
        set_limits(0, 4095, 65535);
        run_gestures(130);
    endtask

    // Random limits and traffic, with idling switched on and off per burst.
    task automatic test_random_traffic();
        for (int burst = 0; burst < 5; burst++)
        begin
            set_limits($urandom_range(20, 2000), $urandom_range(2, 300),
                       $urandom_range(10, 3000));
            tx_idle_en = ($urandom_range(0, 2) != 0);
            rx_idle_en = ($urandom_range(0, 2) != 0);
            run_gestures(110);
        end
        // Finish back on the reset limits.
        set_limits(MAX_PRESS_RST, MAX_MOVE_RST, DBL_WINDOW_RST);
        run_gestures(60);
    endtask

    initial
    begin : stimulus
        int waited;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_MAX_PRESS;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_DOWN;
        now_ms        = $urandom;
        reset_tracker();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_result_backpressure();
        test_limit_extremes();
        test_random_traffic();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (taps_due.size() != 0 && waited < END_WAIT_MAX)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (taps_due.size() != 0)
        begin
            flag_mismatch($sformatf("%0d predicted tap reports never arrived",
                                    taps_due.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
